// ===== src/verlet_particle_box_step_macros.svh =====
// Assertion helpers used by vpbs_core.
`ifndef VERLET_PARTICLE_BOX_STEP_MACROS_SVH
`define VERLET_PARTICLE_BOX_STEP_MACROS_SVH
// Same-cycle implication.
`define VPBS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vpbs: same-cycle check failed");
// Next-cycle implication.
`define VPBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vpbs: next-cycle check failed");
`endif

// ===== src/vpbs_pkg.sv =====
`default_nettype none
package vpbs_pkg;

	localparam int NUM_AXES = 3;

	typedef logic [1:0] axis_t;
	localparam axis_t AX_X    = 2'd0;
	localparam axis_t AX_LAST = 2'd2;

	typedef struct packed {
		logic               clear_forces;
		logic               add_force;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [2:0]         wall_hits;
		logic               saturated;
	} result_t;

	typedef enum logic [1:0] {OP_STEP, OP_CLEAR, OP_ADD, OP_CLEAR_ADD} op_t;

	// force_v[0] is x
	typedef struct packed {
		op_t              op;
		logic [2:0][31:0] force_v;
	} cmd_t;

	// dt2 is dt*dt/2^16; a full 17-bit dt needs 18 bits here
	typedef struct packed {
		logic [20:0] radius;
		logic [20:0] mass;
		logic [16:0] rest;
		logic [17:0] dt2;
		logic [30:0] half;
	} cfg_t;

	typedef struct packed {
		logic        we;
		axis_t       ax;
		logic [31:0] value;
	} start_wr_t;

	typedef enum logic [2:0] {
		REG_RADIUS, REG_MASS, REG_REST, REG_DT, REG_HALF,
		REG_START_X, REG_START_Y, REG_START_Z
	} reg_idx_t;

	localparam logic [20:0] RADIUS_RST = 21'd13107;
	localparam logic [20:0] MASS_RST   = 21'd13107;
	localparam logic [16:0] REST_RST   = 17'd13107;
	localparam logic [16:0] DT_RST     = 17'd1092;
	localparam logic [17:0] DT2_RST    = 18'((1092 * 1092) / 65536);
	localparam logic [30:0] HALF_RST   = 31'd655360;
	localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642908;
	localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
	localparam logic [63:0] UNIT_LEN_SQ = 64'h0000_0001_0000_0000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ADD, ST_SQ_MUL, ST_SQ_ACC, ST_SQ_CMP, ST_SQRT,
		ST_DRAG_GO, ST_DRAG_WAIT, ST_FSUB, ST_ACC_GO, ST_ACC_WAIT,
		ST_DMUL, ST_POS, ST_WCHK, ST_WPV, ST_WMUL, ST_WUPD, ST_DONE
	} state_t;

	function automatic logic signed [49:0] sx50(input logic signed [31:0] v);
		return {{18{v[31]}}, v};
	endfunction

	// {clamped, value}
	function automatic logic [32:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) begin
			return {1'b1, 32'h7fff_ffff};
		end else if (v < -50'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	// divide by 2^16, rounding toward zero
	function automatic logic signed [49:0] trunc16(input logic signed [65:0] p);
		logic signed [65:0] adj;
		logic signed [65:0] sh;
		adj = p + (p[65] ? 66'sd65535 : 66'sd0);
		sh = adj >>> 16;
		return sh[49:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/verlet_particle_box_step.sv =====
// Flow: an item without a force add runs three divides on the bit-serial divider; with
// an add, a force-add pass comes first, and when the force is longer than 1.0 an integer
// root plus three more divides follow, so the divider is used three to six times.
// The core works on one item at a time; a 2-deep input queue and a result register
// let both sides keep moving while the core works.
// Reset (arst_n low, async): registers to defaults, force {0,9.81,0}, drag {0,1,0}, pos 0.
`default_nettype none
module verlet_particle_box_step import vpbs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input queue side
	input  wire logic        push,
	input  wire item_t       item,
	output logic             full,
	// result register side
	output logic             empty,
	input  wire logic        pop,
	output result_t          result,
	// register writes
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	// front: queue + op decode
	logic      cmd_valid, cmd_take;
	cmd_t      cmd;

	// back: arithmetic core
	cfg_t      cfg;
	start_wr_t start_wr;
	logic      res_free, res_push;
	result_t   res;

	// register file; start registers only move the position, nothing to keep
	logic [20:0] radius_q, mass_q;
	logic [16:0] rest_q, dt_q;
	logic [17:0] dt2_q;
	logic [30:0] half_q;
	logic [33:0] dt_sq;

	// result register
	logic    out_valid_q;
	result_t out_q;

	vpbs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	vpbs_core u_core (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .cfg(cfg), .start_wr(start_wr),
		.res_free(res_free), .res_push(res_push), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			mass_q   <= MASS_RST;
			rest_q   <= REST_RST;
			dt_q     <= DT_RST;
			half_q   <= HALF_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RADIUS:  radius_q <= cfg_data[20:0];
				REG_MASS:    mass_q   <= cfg_data[20:0];
				REG_REST:    rest_q   <= cfg_data[16:0];
				REG_DT:      dt_q     <= cfg_data[16:0];
				REG_HALF:    half_q   <= cfg_data[30:0];
				REG_START_X,
				REG_START_Y,
				REG_START_Z: half_q   <= half_q;
			endcase
		end
	end

	always_comb begin
		start_wr.we    = 1'b0;
		start_wr.ax    = AX_X;
		start_wr.value = cfg_data;
		unique case (reg_idx_t'(cfg_index))
			REG_START_X: begin
				start_wr.we = cfg_we;
				start_wr.ax = 2'd0;
			end
			REG_START_Y: begin
				start_wr.we = cfg_we;
				start_wr.ax = 2'd1;
			end
			REG_START_Z: begin
				start_wr.we = cfg_we;
				start_wr.ax = 2'd2;
			end
			default: start_wr.we = 1'b0;
		endcase
	end

	// dt^2 in Q16, refreshed every cycle; settles long before the next item
	assign dt_sq = dt_q * dt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt2_q <= DT2_RST;
		end else begin
			dt2_q <= dt_sq[33:16];
		end
	end

	assign cfg.radius = radius_q;
	assign cfg.mass   = mass_q;
	assign cfg.rest   = rest_q;
	assign cfg.dt2    = dt2_q;
	assign cfg.half   = half_q;

	// a result can be loaded in the same cycle the old one is popped
	assign res_free = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;
endmodule
`default_nettype wire

// ===== src/vpbs_front.sv =====
`default_nettype none
module vpbs_front import vpbs_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t item,
	output logic       full,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  wire logic  cmd_take
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t            slot_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	cmd_t            cls;
	logic            do_push, do_pop;

	always_comb begin
		unique case ({item.clear_forces, item.add_force})
			2'b00: cls.op = OP_STEP;
			2'b10: cls.op = OP_CLEAR;
			2'b01: cls.op = OP_ADD;
			2'b11: cls.op = OP_CLEAR_ADD;
		endcase
		cls.force_v = {item.force_z, item.force_y, item.force_x};
	end

	assign full      = (cnt_q == CW'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/vpbs_div.sv =====
`default_nettype none
module vpbs_div import vpbs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic               neg,
	input  wire logic [47:0]        mag,
	input  wire logic [31:0]        den,
	output logic                    busy,
	output logic                    done,
	output logic signed [49:0]      quo
);
	// restoring divide, one quotient bit per cycle
	logic [31:0] rem_q, den_q;
	logic [47:0] quo_q;
	logic [5:0]  cnt_q;
	logic        neg_q, busy_q, done_q;
	logic [32:0] trial;
	logic        qbit;

	assign trial = {rem_q, quo_q[47]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[46:0], qbit};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
endmodule
`default_nettype wire

// ===== src/vpbs_sqrt.sv =====
`default_nettype none
module vpbs_sqrt import vpbs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] n,
	output logic             busy,
	output logic             done,
	output logic [31:0]      root
);
	// digit-by-digit integer root, two radicand bits per cycle
	logic [63:0] n_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			n_q   <= n;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[31:0];
endmodule
`default_nettype wire

// ===== src/vpbs_core.sv =====
`default_nettype none
`include "verlet_particle_box_step_macros.svh"
module vpbs_core import vpbs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire cmd_t      cmd,
	output logic           cmd_take,
	input  wire cfg_t      cfg,
	input  wire start_wr_t start_wr,
	input  wire logic      res_free,
	output logic           res_push,
	output result_t        res
);
	state_t state_q, state_d;
	axis_t  ax_q, ax_d, ax_next;
	logic   ax_last;

	logic signed [31:0] force_q [NUM_AXES];
	logic signed [31:0] drag_q  [NUM_AXES];
	logic signed [31:0] cur_q   [NUM_AXES];
	logic signed [31:0] prev_q  [NUM_AXES];
	cmd_t               cmd_q;
	logic signed [31:0] acc_q, w_q;
	logic [63:0]        sq_q;
	logic [2:0]         hits_q;
	logic               sat_q;
	logic signed [65:0] prod_q;

	logic signed [32:0] mult_a, mult_b;
	logic signed [31:0] f_cur, d_cur, p_cur, v_prev, in_f;
	logic [32:0]        add_r, fsub_r, pos_r, pv_r, bnc_r, quo_r;
	logic [31:0]        f_abs, mass_eff;

	logic        div_go, div_busy, div_done, sqrt_go, sqrt_busy, sqrt_done;
	logic [31:0] div_den, sqrt_root;
	logic signed [49:0] div_quo;

	logic signed [34:0] p35, r35, h35, whi35, wlo35;
	logic               hi_hit, lo_hit, w_hit;
	logic signed [31:0] w_sel;

	assign f_cur   = force_q[ax_q];
	assign d_cur   = drag_q[ax_q];
	assign p_cur   = cur_q[ax_q];
	assign v_prev  = prev_q[ax_q];
	assign in_f    = cmd_q.force_v[ax_q];
	assign ax_last = (ax_q == AX_LAST);
	assign ax_next = ax_last ? AX_X : ax_q + 1'b1;

	assign add_r  = sat32(sx50(f_cur) + sx50(in_f));
	assign fsub_r = sat32(sx50(f_cur) - sx50(d_cur));
	assign pos_r  = sat32(sx50(p_cur) + sx50(p_cur) - sx50(v_prev) + trunc16(prod_q));
	assign pv_r   = sat32(sx50(v_prev) - (sx50(p_cur) - sx50(w_q)));
	assign bnc_r  = sat32(sx50(v_prev) + trunc16(prod_q));
	assign quo_r  = sat32(div_quo);

	// walls: x checks the high wall first, y and z the low wall first
	assign p35   = {{3{p_cur[31]}}, p_cur};
	assign r35   = $signed({14'b0, cfg.radius});
	assign h35   = $signed({4'b0, cfg.half});
	assign whi35 = h35 - r35;
	assign wlo35 = r35 - h35;
	assign hi_hit = (p35 + r35) >= h35;
	assign lo_hit = (p35 - r35) <= -h35;
	assign w_hit  = hi_hit || lo_hit;
	assign w_sel  = (ax_q == AX_X) ? (hi_hit ? whi35[31:0] : wlo35[31:0])
	                               : (lo_hit ? wlo35[31:0] : whi35[31:0]);

	assign f_abs    = f_cur[31] ? 32'(-f_cur) : f_cur;
	assign mass_eff = (cfg.mass == '0) ? 32'd1 : {11'b0, cfg.mass};
	assign div_den  = (state_q == ST_DRAG_GO) ? sqrt_root : mass_eff;

	vpbs_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .neg(f_cur[31]),
		.mag({f_abs, 16'b0}), .den(div_den), .busy(div_busy), .done(div_done),
		.quo(div_quo)
	);

	vpbs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(sqrt_go), .n(sq_q),
		.busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
	);

	// shared multiplier, product registered
	always_comb begin
		mult_a = '0;
		mult_b = '0;
		unique case (state_q)
			ST_SQ_MUL: begin
				mult_a = {f_cur[31], f_cur};
				mult_b = {f_cur[31], f_cur};
			end
			ST_DMUL: begin
				mult_a = {acc_q[31], acc_q};
				mult_b = $signed({15'b0, cfg.dt2});
			end
			ST_WMUL: begin
				mult_a = {w_q[31], w_q} - {v_prev[31], v_prev};
				mult_b = $signed({16'b0, cfg.rest});
			end
			default: begin
				mult_a = '0;
				mult_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mult_a * mult_b;
	end

	always_comb begin
		state_d  = state_q;
		ax_d     = ax_q;
		cmd_take = 1'b0;
		div_go   = 1'b0;
		sqrt_go  = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					ax_d     = AX_X;
					state_d  = (cmd.op == OP_ADD || cmd.op == OP_CLEAR_ADD) ? ST_ADD
					                                                       : ST_FSUB;
				end
			end
			ST_ADD: begin
				ax_d = ax_next;
				if (ax_last) begin
					state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL: state_d = ST_SQ_ACC;
			ST_SQ_ACC: begin
				ax_d    = ax_next;
				state_d = ax_last ? ST_SQ_CMP : ST_SQ_MUL;
			end
			ST_SQ_CMP: begin
				if (sq_q > UNIT_LEN_SQ) begin
					sqrt_go = 1'b1;
					state_d = ST_SQRT;
				end else begin
					state_d = ST_FSUB;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_DRAG_GO;
				end
			end
			ST_DRAG_GO: begin
				div_go  = 1'b1;
				state_d = ST_DRAG_WAIT;
			end
			ST_DRAG_WAIT: begin
				if (div_done) begin
					ax_d    = ax_next;
					state_d = ax_last ? ST_FSUB : ST_DRAG_GO;
				end
			end
			ST_FSUB: state_d = ST_ACC_GO;
			ST_ACC_GO: begin
				div_go  = 1'b1;
				state_d = ST_ACC_WAIT;
			end
			ST_ACC_WAIT: begin
				if (div_done) begin
					state_d = ST_DMUL;
				end
			end
			ST_DMUL: state_d = ST_POS;
			ST_POS: begin
				ax_d    = ax_next;
				state_d = ax_last ? ST_WCHK : ST_FSUB;
			end
			ST_WCHK: begin
				if (w_hit) begin
					state_d = ST_WPV;
				end else begin
					ax_d    = ax_next;
					state_d = ax_last ? ST_DONE : ST_WCHK;
				end
			end
			ST_WPV:  state_d = ST_WMUL;
			ST_WMUL: state_d = ST_WUPD;
			ST_WUPD: begin
				ax_d    = ax_next;
				state_d = ax_last ? ST_DONE : ST_WCHK;
			end
			ST_DONE: begin
				if (res_free) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= AX_X;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
		end
	end

	// particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				force_q[i] <= '0;
				drag_q[i]  <= '0;
				cur_q[i]   <= '0;
				prev_q[i]  <= '0;
			end
			force_q[1] <= GRAVITY_Q16;
			drag_q[1]  <= ONE_Q16;
			sat_q      <= 1'b0;
			hits_q     <= '0;
		end else begin
			if (start_wr.we) begin
				cur_q[start_wr.ax] <= start_wr.value;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						sat_q  <= 1'b0;
						hits_q <= '0;
						if (cmd.op == OP_CLEAR || cmd.op == OP_CLEAR_ADD) begin
							for (int i = 0; i < NUM_AXES; i++) begin
								force_q[i] <= '0;
								drag_q[i]  <= '0;
							end
						end
					end
				end
				ST_ADD: begin
					force_q[ax_q] <= add_r[31:0];
					sat_q         <= sat_q | add_r[32];
				end
				ST_SQ_CMP: begin
					if (!(sq_q > UNIT_LEN_SQ)) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							drag_q[i] <= force_q[i];
						end
					end
				end
				ST_DRAG_WAIT: begin
					if (div_done) begin
						drag_q[ax_q] <= quo_r[31:0];
						sat_q        <= sat_q | quo_r[32];
					end
				end
				ST_FSUB: begin
					force_q[ax_q] <= fsub_r[31:0];
					sat_q         <= sat_q | fsub_r[32];
				end
				ST_ACC_WAIT: begin
					if (div_done) begin
						sat_q <= sat_q | quo_r[32];
					end
				end
				ST_POS: begin
					cur_q[ax_q]  <= pos_r[31:0];
					prev_q[ax_q] <= p_cur;
					sat_q        <= sat_q | pos_r[32];
				end
				ST_WCHK: begin
					if (w_hit) begin
						hits_q[ax_q] <= 1'b1;
					end
				end
				ST_WPV: begin
					prev_q[ax_q] <= pv_r[31:0];
					sat_q        <= sat_q | pv_r[32];
				end
				ST_WUPD: begin
					cur_q[ax_q]  <= bnc_r[31:0];
					prev_q[ax_q] <= w_q;
					sat_q        <= sat_q | bnc_r[32];
				end
				default: begin
					sat_q <= sat_q;
				end
			endcase
		end
	end

	// payload scratch
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
			sq_q  <= '0;
		end
		if (state_q == ST_SQ_ACC) begin
			sq_q <= sq_q + prod_q[63:0];
		end
		if (state_q == ST_ACC_WAIT && div_done) begin
			acc_q <= quo_r[31:0];
		end
		if (state_q == ST_WCHK) begin
			w_q <= w_sel;
		end
	end

	assign res.pos_x     = cur_q[0];
	assign res.pos_y     = cur_q[1];
	assign res.pos_z     = cur_q[2];
	assign res.wall_hits = hits_q;
	assign res.saturated = sat_q;

	`VPBS_ASSERT_NOW(a_div_free, div_go, !div_busy)
	`VPBS_ASSERT_NOW(a_sqrt_free, sqrt_go, !sqrt_busy)
	`VPBS_ASSERT_NOW(a_push_room, res_push, res_free && state_q == ST_DONE)
	`VPBS_ASSERT_NEXT(a_take_starts, cmd_take, state_q != ST_IDLE)
endmodule
`default_nettype wire
